FILE: sv/ber_indefinite_length_scanner_macros.svh
// Assertion macros shared by the BER indefinite-length scanner RTL.
// Depends on nothing; include with the bare file name.
`ifndef BER_INDEFINITE_LENGTH_SCANNER_MACROS_SVH
`define BER_INDEFINITE_LENGTH_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BERSCAN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("berscan assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BERSCAN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("berscan assertion failed");

`endif

FILE: sv/berscan_pkg.sv
// Package for the BER indefinite-length scanner: widths, octet constants,
// parse phases, status codes and the word structs. Depends on nothing.
`default_nettype none

package berscan_pkg;

    localparam int POS_WIDTH      = 32;
    localparam int LEVEL_WIDTH    = 16;
    localparam int MAX_LEN_OCTETS = 7;
    localparam int SKIP_WIDTH     = 8 * MAX_LEN_OCTETS;
    localparam int LENCNT_WIDTH   = $clog2(MAX_LEN_OCTETS + 1);
    localparam int COUNT_WIDTH    = 32;
    localparam int STATUS_WIDTH   = 3;

    localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = '1;

    // Octet constants
    localparam logic [4:0] TAG_LOW_ALL    = 5'h1f;
    localparam logic [7:0] LEN_SHORT_MAX  = 8'h7f;
    localparam logic [7:0] LEN_INDEF      = 8'h80;
    localparam int         BIT_CONSTRUCT  = 5;
    localparam int         BIT_MORE       = 7;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_EOC2    = 3'd1,
        PH_LONGTAG = 3'd2,
        PH_LEN     = 3'd3,
        PH_LENOCT  = 3'd4,
        PH_SKIP    = 3'd5
    } t_phase;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK          = 3'd0,
        ST_BAD_LEN     = 3'd1,
        ST_INDEF_PRIM  = 3'd2,
        ST_BAD_EOC     = 3'd3,
        ST_OVERRUN     = 3'd4,
        ST_MISSING_EOC = 3'd5,
        ST_NESTING     = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0] status;
        logic [COUNT_WIDTH-1:0]  byte_count;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/berscan_if.sv
// Valid/ready channel interfaces for the BER scanner: octet input, result output.
// Depends on berscan_pkg for field widths.
`default_nettype none

interface berscan_in_if import berscan_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface berscan_out_if import berscan_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [STATUS_WIDTH-1:0] status;
    logic [COUNT_WIDTH-1:0]  byte_count;

    modport source (output valid, output status, output byte_count, input ready);
    modport sink   (input valid, input status, input byte_count, output ready);
endinterface

`default_nettype wire

FILE: sv/berscan_in_stage.sv
// Input register of the BER scanner: captures one octet word per handshake.
// Depends on berscan_pkg and berscan_in_if.
`default_nettype none

module berscan_in_stage import berscan_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    berscan_in_if.sink   i_in,
    input  wire logic    i_take,
    output t_item        o_item,
    output logic         o_item_valid
);

    logic  r_valid;
    t_item r_item;

    assign i_in.ready   = !r_valid || i_take;
    assign o_item       = r_item;
    assign o_item_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.data_byte <= i_in.data_byte;
            r_item.last_byte <= i_in.last_byte;
        end
    end

endmodule

`default_nettype wire

FILE: sv/berscan_out_stage.sv
// Result register of the BER scanner: holds one result word until taken.
// Depends on berscan_pkg and berscan_out_if.
`default_nettype none

module berscan_out_stage import berscan_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_res_valid,
    input  t_result      i_result,
    output logic         o_free,
    berscan_out_if.source o_out
);

    logic    r_valid;
    t_result r_result;

    assign o_free           = !r_valid || o_out.ready;
    assign o_out.valid      = r_valid;
    assign o_out.status     = r_result.status;
    assign o_out.byte_count = r_result.byte_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

FILE: sv/berscan_core.sv
// Parse state and per-octet step logic of the BER indefinite-length scanner.
// Depends on berscan_pkg and the assertion macros header.
`default_nettype none
`include "ber_indefinite_length_scanner_macros.svh"

module berscan_core import berscan_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_item_valid,
    input  t_item     i_item,
    input  wire logic i_out_free,
    output logic      o_take,
    output logic      o_res_valid,
    output t_result   o_result
);

    t_phase                  r_phase, n_phase;
    logic [LEVEL_WIDTH-1:0]  r_nest, n_nest;
    logic                    r_constructed, n_constructed;
    logic [LENCNT_WIDTH-1:0] r_left, n_left;
    logic [LENCNT_WIDTH-1:0] r_len_total, n_len_total;
    logic [SKIP_WIDTH-1:0]   r_skip, n_skip;
    logic [POS_WIDTH-1:0]    r_pos, n_pos;
    logic                    r_finished;

    logic [7:0]              data;
    logic                    last;
    logic [6:0]              long_cnt;
    logic                    emit;
    t_status                 emit_status;
    logic [POS_WIDTH-1:0]    emit_pos;
    logic [LENCNT_WIDTH-1:0] done_cnt;

    assign data     = i_item.data_byte;
    assign last     = i_item.last_byte;
    assign long_cnt = data[6:0];

    assign o_take      = i_item_valid && i_out_free;
    assign o_res_valid = o_take && !r_finished && emit;
    assign o_result.status     = emit_status;
    assign o_result.byte_count = COUNT_WIDTH'(emit_pos);

    // Next state for one octet
    always_comb begin
        n_phase       = r_phase;
        n_nest        = r_nest;
        n_constructed = r_constructed;
        n_left        = r_left;
        n_len_total   = r_len_total;
        n_skip        = r_skip;
        n_pos         = r_pos + 1'b1;
        unique case (r_phase)
            PH_TAG: begin
                if (data == 8'h00) begin
                    n_phase = PH_EOC2;
                end else begin
                    n_constructed = data[BIT_CONSTRUCT];
                    n_phase = (data[4:0] == TAG_LOW_ALL) ? PH_LONGTAG : PH_LEN;
                end
            end
            PH_EOC2: begin
                if (data == 8'h00) begin
                    n_nest  = r_nest - 1'b1;
                    n_phase = PH_TAG;
                end
            end
            PH_LONGTAG: begin
                if (!data[BIT_MORE]) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                priority if (data <= LEN_SHORT_MAX) begin
                    n_skip  = SKIP_WIDTH'(data);
                    n_phase = (data != 8'h00) ? PH_SKIP : PH_TAG;
                end else if (data == LEN_INDEF) begin
                    if (r_constructed && r_nest != LEVEL_MAX) begin
                        n_nest  = r_nest + 1'b1;
                        n_phase = PH_TAG;
                    end
                end else begin
                    n_left      = LENCNT_WIDTH'(long_cnt);
                    n_len_total = LENCNT_WIDTH'(long_cnt);
                    n_skip      = '0;
                    n_phase     = PH_LENOCT;
                end
            end
            PH_LENOCT: begin
                n_skip = SKIP_WIDTH'({r_skip, data});
                if (r_left != '0) begin
                    n_left = r_left - 1'b1;
                end
                if (r_left <= LENCNT_WIDTH'(1)) begin
                    n_phase = (n_skip != '0) ? PH_SKIP : PH_TAG;
                end
            end
            PH_SKIP: begin
                if (r_skip != '0) begin
                    n_skip = r_skip - 1'b1;
                end
                if (r_skip <= SKIP_WIDTH'(1)) begin
                    n_phase = PH_TAG;
                end
            end
            default: begin
                n_phase = PH_TAG;
                n_pos   = r_pos;
            end
        endcase
    end

    // Result for one octet
    always_comb begin
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_pos    = n_pos;
        done_cnt    = n_len_total - n_left;
        unique case (r_phase)
            PH_TAG, PH_LONGTAG: begin
                if (last) begin
                    emit        = 1'b1;
                    emit_status = ST_OVERRUN;
                    emit_pos    = r_pos;
                end
            end
            PH_EOC2: begin
                if (data != 8'h00) begin
                    emit        = 1'b1;
                    emit_status = ST_BAD_EOC;
                end else if (r_nest == LEVEL_WIDTH'(1)) begin
                    emit        = 1'b1;
                    emit_status = ST_OK;
                end
            end
            PH_LEN: begin
                if (data == LEN_INDEF) begin
                    if (!r_constructed) begin
                        emit        = 1'b1;
                        emit_status = ST_INDEF_PRIM;
                    end else if (r_nest == LEVEL_MAX) begin
                        emit        = 1'b1;
                        emit_status = ST_NESTING;
                    end
                end else if (data > LEN_INDEF && long_cnt > 7'(MAX_LEN_OCTETS)) begin
                    emit        = 1'b1;
                    emit_status = ST_BAD_LEN;
                end
            end
            default: ;
        endcase
        // End of data with no earlier verdict
        if (!emit && last) begin
            emit = 1'b1;
            priority if (n_phase == PH_TAG) begin
                emit_status = ST_MISSING_EOC;
            end else if (n_phase == PH_LENOCT) begin
                emit_status = ST_OVERRUN;
                emit_pos    = n_pos - POS_WIDTH'(done_cnt);
            end else begin
                emit_status = ST_OVERRUN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TAG;
            r_nest        <= LEVEL_WIDTH'(1);
            r_constructed <= 1'b0;
            r_left        <= '0;
            r_len_total   <= '0;
            r_skip        <= '0;
            r_pos         <= '0;
            r_finished    <= 1'b0;
        end else if (o_take) begin
            if (last) begin
                r_phase       <= PH_TAG;
                r_nest        <= LEVEL_WIDTH'(1);
                r_constructed <= 1'b0;
                r_left        <= '0;
                r_len_total   <= '0;
                r_skip        <= '0;
                r_pos         <= '0;
                r_finished    <= 1'b0;
            end else if (!r_finished) begin
                if (emit) begin
                    r_finished <= 1'b1;
                end else begin
                    r_phase       <= n_phase;
                    r_nest        <= n_nest;
                    r_constructed <= n_constructed;
                    r_left        <= n_left;
                    r_len_total   <= n_len_total;
                    r_skip        <= n_skip;
                    r_pos         <= n_pos;
                end
            end
        end
    end

    `BERSCAN_ASSERT_NOW(a_nest_live, i_clk, i_rst_n, !r_finished, r_nest != '0)
    `BERSCAN_ASSERT_NOW(a_lenoct_count, i_clk, i_rst_n, r_phase == PH_LENOCT, (r_left != '0) && (r_left <= r_len_total))
    `BERSCAN_ASSERT_NOW(a_skip_live, i_clk, i_rst_n, r_phase == PH_SKIP, r_skip != '0)
    `BERSCAN_ASSERT_NOW(a_quiet_done, i_clk, i_rst_n, r_finished, !o_res_valid)
    `BERSCAN_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, o_take && last, (r_pos == '0) && !r_finished && (r_phase == PH_TAG))

endmodule

`default_nettype wire

FILE: sv/ber_indefinite_length_scanner.sv
// Top level of the BER indefinite-length end-of-contents scanner.
// Depends on berscan_pkg, berscan_if, berscan_in_stage, berscan_core, berscan_out_stage.
//
//   port    | dir | word fields               | meaning
//   --------+-----+---------------------------+----------------------------------
//   i_in    | in  | data_byte[7:0], last_byte | one content octet, last marks end
//   o_out   | out | status[2:0], byte_count   | verdict and consumed/stop offset
//
// One octet per cycle sustained while o_out is not stalled; the parse step is one
// short combinational pass from the input register into the result register.
// i_rst_n is synchronous, active low, and restores the scan to expecting a tag
// at nesting level one. A stalled o_out holds its word and stops the core; the
// input register keeps taking octets while it has room. After a verdict, octets
// are dropped without a result through the next last.
`default_nettype none

module ber_indefinite_length_scanner import berscan_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    berscan_in_if.sink    i_in,
    berscan_out_if.source o_out
);

    t_item   item;
    logic    item_valid;
    logic    take;
    logic    out_free;
    logic    res_valid;
    t_result result;

    // Capture incoming octets
    berscan_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_take       (take),
        .o_item       (item),
        .o_item_valid (item_valid)
    );

    // Advance the parse one octet and decide the verdict
    berscan_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .i_out_free   (out_free),
        .o_take       (take),
        .o_res_valid  (res_valid),
        .o_result     (result)
    );

    // Hold the verdict until the sink takes it
    berscan_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_result    (result),
        .o_free      (out_free),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
